@@ design/pva_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pva_pkg: shared types and constants of the voice allocator
// Field widths, result codes and the voice store command struct.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int unsigned KEY_W    = 21;
  localparam int unsigned FREQ_W   = 20;
  localparam int unsigned BUSY_W   = 8;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned VIDX_W   = 3;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned HW_VOICES = 8;

  localparam int unsigned DEF_MAX_VOICES = 8;
  localparam int unsigned DEF_COUNT_BITS = 8;

  localparam logic [CFG_W-1:0] VOICES_RESET = 4'd8;

  localparam logic OP_PLAY = 1'b0;
  localparam logic OP_STOP = 1'b1;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_COUNT = 3'd3,
    ACT_DROP  = 3'd4
  } action_e;

  // write command to the voice store
  typedef struct packed {
    logic wr_tag;
    logic wr_count;
    logic set_valid;
    logic clr_valid;
  } store_cmd_t;

endpackage
`default_nettype wire

@@ design/pva_voice_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pva_voice_store: per-voice tag and hold count storage
// Tags and counts in a one-write, one-read memory with registered read;
// tag valid bits in flops cleared by reset.
// ----------------------------------------------------------------------------
module pva_voice_store import pva_pkg::*; #(
  parameter int unsigned MAX_VOICES = DEF_MAX_VOICES,
  parameter int unsigned COUNT_BITS = DEF_COUNT_BITS,
  localparam int unsigned AW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  rd_en_i,
  input  wire logic [AW-1:0]         rd_addr_i,
  output logic      [KEY_W-1:0]      rd_tag_o,
  output logic      [COUNT_BITS-1:0] rd_count_o,
  output logic      [MAX_VOICES-1:0] valid_o,
  input  wire store_cmd_t            cmd_i,
  input  wire logic [AW-1:0]         wr_addr_i,
  input  wire logic [KEY_W-1:0]      wr_tag_i,
  input  wire logic [COUNT_BITS-1:0] wr_count_i
);

  logic [KEY_W-1:0]      tag_mem [MAX_VOICES];
  logic [COUNT_BITS-1:0] cnt_mem [MAX_VOICES];
  logic [MAX_VOICES-1:0] valid_q, valid_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_tag) begin
      tag_mem[wr_addr_i] <= wr_tag_i;
    end
    if (cmd_i.wr_count) begin
      cnt_mem[wr_addr_i] <= wr_count_i;
    end
    if (rd_en_i) begin
      rd_tag_o   <= tag_mem[rd_addr_i];
      rd_count_o <= cnt_mem[rd_addr_i];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.set_valid) begin
      valid_d[wr_addr_i] = 1'b1;
    end
    if (cmd_i.clr_valid) begin
      valid_d[wr_addr_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign valid_o = valid_q;

endmodule
`default_nettype wire

@@ design/polyphonic_voice_allocator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_top: reference-counted voice allocator
// Matches note events against voice tags by a sequential scan and starts,
// counts or stops voices; one result transaction per input transaction.
// ----------------------------------------------------------------------------
// Throughput: one item at a time; the next input transaction is taken the
//   cycle after the result is loaded. The scan reads one voice per cycle
//   through the store's single registered read port and ends at a match or
//   after the active voices (0..8); a negative key skips it. A stalled result
//   holds the sequencer in resolve.
// Reset: asynchronous, active low; clears the tag valid bits, the sequencer
//   and the result valid flag, and sets voices_in_use to 8. Tags and counts
//   are not cleared: they are only read behind a valid bit.
module polyphonic_voice_allocator_top import pva_pkg::*; #(
  parameter int unsigned MAX_VOICES = DEF_MAX_VOICES,
  parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write channel
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic        [CFG_W-1:0]  voices_in_use_i,
  // input channel
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     opcode_i,
  input  wire logic signed [KEY_W-1:0]  key_i,
  input  wire logic        [BUSY_W-1:0] voice_busy_i,
  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic             [2:0]        action_o,
  output logic             [VIDX_W-1:0] voice_index_o,
  output logic             [FREQ_W-1:0] voice_frequency_o,
  output logic             [CNT_W-1:0]  busy_count_o
);

  localparam int unsigned AW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  // voices that can ever be searched: the result index is three bits wide
  localparam int unsigned LIMIT = (MAX_VOICES < HW_VOICES) ? MAX_VOICES : HW_VOICES;
  localparam logic [CNT_W-1:0] LIMIT_N = CNT_W'(LIMIT);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_SCAN    = 3'b010,
    ST_RESOLVE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // configuration register
  logic [CFG_W-1:0] voices_q;

  // per-item registers
  logic              op_q;
  logic [KEY_W-1:0]  key_q;
  logic              key_neg_q;
  logic [CNT_W-1:0]  n_q;
  logic [CNT_W-1:0]  nbusy_q;
  logic              idle_ok_q;
  logic [VIDX_W-1:0] idle_idx_q;
  logic [CNT_W-1:0]  scan_idx_q, scan_idx_d;
  logic [AW-1:0]     chk_addr_q, chk_addr_d;
  logic              chk_vld_q, chk_vld_d;
  logic              found_q, found_d;

  // result register
  logic              out_valid_q, out_valid_d;
  action_e           act_q, act_d;
  logic [VIDX_W-1:0] vidx_q, vidx_d;
  logic [FREQ_W-1:0] freq_q, freq_d;

  // voice store
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [KEY_W-1:0]      rd_tag;
  logic [COUNT_BITS-1:0] rd_count;
  logic [MAX_VOICES-1:0] valid_vec;
  store_cmd_t            cmd;
  logic [AW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wr_count;

  // decode at the input transaction
  logic              in_fire;
  logic [CNT_W-1:0]  n_acc;
  logic [CNT_W-1:0]  nbusy_acc;
  logic              idle_ok_acc;
  logic [VIDX_W-1:0] idle_idx_acc;

  logic hit;
  logic res_fire;

  assign in_fire     = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // active voices: min(voices_in_use, MAX_VOICES, 8)
  assign n_acc = (voices_q > LIMIT_N) ? LIMIT_N : voices_q;

  // busy count over active voices and lowest idle voice
  always_comb begin
    nbusy_acc    = '0;
    idle_ok_acc  = 1'b0;
    idle_idx_acc = '0;
    for (int i = 0; i < HW_VOICES; i++) begin
      if (CNT_W'(i) < n_acc) begin
        nbusy_acc = nbusy_acc + CNT_W'(voice_busy_i[i]);
      end
    end
    for (int i = HW_VOICES - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < n_acc) && !voice_busy_i[i]) begin
        idle_ok_acc  = 1'b1;
        idle_idx_acc = VIDX_W'(i);
      end
    end
  end

  // tag compare on the entry read in the previous cycle
  assign hit = chk_vld_q && valid_vec[chk_addr_q] && (rd_tag == key_q);

  // result can be loaded once the output register is free or draining
  assign res_fire = (state_q == ST_RESOLVE) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    chk_addr_d = chk_addr_q;
    chk_vld_d  = chk_vld_q;
    found_d    = found_q;
    rd_en      = 1'b0;
    rd_addr    = AW'(scan_idx_q);
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          scan_idx_d = '0;
          chk_vld_d  = 1'b0;
          found_d    = 1'b0;
          state_d    = key_i[KEY_W-1] ? ST_RESOLVE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          found_d = 1'b1;
          state_d = ST_RESOLVE;
        end else if (scan_idx_q < n_q) begin
          rd_en      = 1'b1;
          chk_addr_d = rd_addr;
          chk_vld_d  = 1'b1;
          scan_idx_d = scan_idx_q + CNT_W'(1);
        end else begin
          chk_vld_d = 1'b0;
          state_d   = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (res_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // resolution: store update and result
  always_comb begin
    cmd         = '0;
    wr_addr     = chk_addr_q;
    wr_count    = rd_count;
    act_d       = act_q;
    vidx_d      = vidx_q;
    freq_d      = freq_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (res_fire) begin
      out_valid_d = 1'b1;
      act_d       = ACT_NONE;
      vidx_d      = '0;
      freq_d      = '0;
      if (!key_neg_q) begin
        if (op_q == OP_PLAY) begin
          if (found_q) begin
            // saturating increment
            cmd.wr_count = (rd_count != CNT_MAX);
            wr_count     = rd_count + CNT_ONE;
            act_d        = ACT_COUNT;
            vidx_d       = VIDX_W'(chk_addr_q);
          end else if (idle_ok_q) begin
            wr_addr       = AW'(idle_idx_q);
            wr_count      = CNT_ONE;
            cmd.wr_tag    = 1'b1;
            cmd.wr_count  = 1'b1;
            cmd.set_valid = 1'b1;
            act_d         = ACT_START;
            vidx_d        = idle_idx_q;
            freq_d        = key_q[FREQ_W-1:0];
          end else begin
            act_d = ACT_DROP;
          end
        end else if (found_q) begin
          vidx_d = VIDX_W'(chk_addr_q);
          if (rd_count <= CNT_ONE) begin
            // last holder released: free the voice
            cmd.clr_valid = 1'b1;
            act_d         = ACT_STOP;
          end else begin
            cmd.wr_count = 1'b1;
            wr_count     = rd_count - CNT_ONE;
            act_d        = ACT_COUNT;
          end
        end
      end
    end
  end

  pva_voice_store #(
    .MAX_VOICES (MAX_VOICES),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_tag_o   (rd_tag),
    .rd_count_o (rd_count),
    .valid_o    (valid_vec),
    .cmd_i      (cmd),
    .wr_addr_i  (wr_addr),
    .wr_tag_i   (key_q),
    .wr_count_i (wr_count)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      voices_q    <= VOICES_RESET;
      scan_idx_q  <= '0;
      chk_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_idx_q  <= scan_idx_d;
      chk_vld_q   <= chk_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        voices_q <= voices_in_use_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    chk_addr_q <= chk_addr_d;
    act_q      <= act_d;
    vidx_q     <= vidx_d;
    freq_q     <= freq_d;
    if (res_fire) begin
      busy_count_o <= nbusy_q;
    end
    if (in_fire) begin
      op_q       <= opcode_i;
      key_q      <= key_i;
      key_neg_q  <= key_i[KEY_W-1];
      n_q        <= n_acc;
      nbusy_q    <= nbusy_acc;
      idle_ok_q  <= idle_ok_acc;
      idle_idx_q <= idle_idx_acc;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign action_o          = act_q;
  assign voice_index_o     = vidx_q;
  assign voice_frequency_o = freq_q;

`ifndef SYNTHESIS
  // the sequencer is busy in the cycle after an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input taken while an item was in flight");

  // the scan never runs past the active voices
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_idx_q <= n_q))
    else $error("scan index beyond active voices");

  // frequency only carried by a voice start
  a_freq_start_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_o != ACT_START)) |-> (voice_frequency_o == '0))
    else $error("frequency on a result that starts no voice");

  // no voice index on empty or dropped results
  a_vidx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((action_o == ACT_NONE) || (action_o == ACT_DROP)))
      |-> (voice_index_o == '0))
    else $error("voice index on a result without a voice");

  // a stalled result keeps its action
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(action_o)))
    else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire

@@ verif/tb_polyphonic_voice_allocator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyphonic_voice_allocator_top: self-checking bench of the voice allocator
// Drives note transactions from a queue and keeps its own model of the voice
// tags and hold counts. Each result transaction is checked field by field.
// Runs under several voice limits, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_polyphonic_voice_allocator_top;
  import pva_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned GAP_PERCENT  = 12;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned POOL_SIZE    = 8;
  localparam int unsigned SAT_PLAYS    = 258;

  typedef struct {
    logic              opcode;
    logic [KEY_W-1:0]  key;
    logic [BUSY_W-1:0] busy;
  } note_t;

  typedef struct {
    action_e            action;
    logic [VIDX_W-1:0]  voice;
    logic [FREQ_W-1:0]  freq;
    logic [CNT_W-1:0]   sounding;
  } voice_result_t;

  // clock, reset and DUT pins; every input has a known value from time 0
  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_voices = VOICES_RESET;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic                 opcode_drv = OP_PLAY;
  logic [KEY_W-1:0]     key_drv    = '0;
  logic [BUSY_W-1:0]    busy_drv   = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [2:0]           action_mon;
  logic [VIDX_W-1:0]    voice_mon;
  logic [FREQ_W-1:0]    freq_mon;
  logic [CNT_W-1:0]     sounding_mon;

  // model of the allocator: limit register plus per-voice tag, valid and count
  logic [CFG_W-1:0]          voice_limit = VOICES_RESET;
  logic [KEY_W-1:0]          tag_model   [HW_VOICES];
  logic                      live_model  [HW_VOICES];
  logic [DEF_COUNT_BITS-1:0] hold_model  [HW_VOICES];

  note_t         pending_notes[$];    // notes still to be driven
  voice_result_t expected_results[$]; // results owed by the DUT, oldest first
  note_t         driven_note;         // payload currently on the input channel
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  bit          no_gaps    = 1'b0;     // set for a stretch with no idling
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  polyphonic_voice_allocator_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .voices_in_use_i   (cfg_voices),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .opcode_i          (opcode_drv),
    .key_i             (key_drv),
    .voice_busy_i      (busy_drv),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .action_o          (action_mon),
    .voice_index_o     (voice_mon),
    .voice_frequency_o (freq_mon),
    .busy_count_o      (sounding_mon)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Work out the result of one note and update the voice state, as the
  // allocator does. Voices past the limit keep their state but are not
  // searched; matching ignores the busy mask.
  function automatic voice_result_t allocate_note(input note_t ev);
    voice_result_t res;
    int unsigned   lanes;
    int            hit;
    int            i;
    res.action   = ACT_NONE;
    res.voice    = '0;
    res.freq     = '0;
    res.sounding = '0;
    lanes = (voice_limit > HW_VOICES) ? HW_VOICES : voice_limit;
    hit   = -1;
    for (i = 0; i < lanes; i++) begin
      res.sounding = res.sounding + CNT_W'(ev.busy[i]);
    end
    // negative keys leave everything untouched
    if (!ev.key[KEY_W-1]) begin
      for (i = 0; i < lanes; i++) begin
        if (live_model[i] && tag_model[i] == ev.key) begin
          hit = i;
          break;
        end
      end
      if (ev.opcode == OP_PLAY) begin
        if (hit >= 0) begin
          // count saturates at all ones
          if (hold_model[hit] != '1) hold_model[hit]++;
          res.action = ACT_COUNT;
          res.voice  = VIDX_W'(hit);
        end else begin
          res.action = ACT_DROP;
          for (i = 0; i < lanes; i++) begin
            if (!ev.busy[i]) begin
              tag_model[i]  = ev.key;
              live_model[i] = 1'b1;
              hold_model[i] = DEF_COUNT_BITS'(1);
              res.action    = ACT_START;
              res.voice     = VIDX_W'(i);
              res.freq      = ev.key[FREQ_W-1:0];
              break;
            end
          end
        end
      end else if (hit >= 0) begin
        if (hold_model[hit] != '0) hold_model[hit]--;
        if (hold_model[hit] == '0) begin
          live_model[hit] = 1'b0;
          tag_model[hit]  = '0;
          res.action      = ACT_STOP;
        end else begin
          res.action = ACT_COUNT;
        end
        res.voice = VIDX_W'(hit);
      end
    end
    return res;
  endfunction

  // Random note: keys mostly from a small pool so that matches, counts and
  // stops happen often; the rest are negative or arbitrary keys.
  function automatic note_t random_note();
    note_t       ev;
    int unsigned pick;
    ev.opcode = ($urandom_range(99) < 52) ? OP_PLAY : OP_STOP;
    pick = $urandom_range(99);
    if (pick < 80) begin
      ev.key = key_pool[$urandom_range(POOL_SIZE-1)];
    end else if (pick < 90) begin
      ev.key = {1'b1, FREQ_W'($urandom)};
    end else begin
      ev.key = KEY_W'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 15) begin
      ev.busy = '1;                                   // no idle voice: unmatched plays drop
    end else if (pick < 45) begin
      ev.busy = BUSY_W'($urandom);
    end else begin
      ev.busy = BUSY_W'($urandom & $urandom & $urandom); // mostly idle voices
    end
    return ev;
  endfunction

  task automatic push_note(input logic op, input logic [KEY_W-1:0] key,
                           input logic [BUSY_W-1:0] busy);
    note_t ev;
    ev.opcode = op;
    ev.key    = key;
    ev.busy   = busy;
    pending_notes.push_back(ev);
  endtask

  // Block until every note has been driven and every result checked.
  task automatic wait_drained();
    while (pending_notes.size() != 0 || expected_results.size() != 0 || in_valid) begin
      @(posedge clk_i);
    end
  endtask

  // Write the voice limit while the DUT is idle; the model follows at the
  // edge where the write transaction completes.
  task automatic write_voice_limit(input logic [CFG_W-1:0] lanes);
    wait_drained();
    @(posedge clk_i);
    cfg_valid  <= 1'b1;
    cfg_voices <= lanes;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready);
    voice_limit = lanes;
    cfg_valid  <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] lanes, input int unsigned count);
    write_voice_limit(lanes);
    repeat (count) pending_notes.push_back(random_note());
  endtask

  // Input driver: predicts the result of each accepted note, then either
  // presents the next note or leaves the input channel idle.
  always @(posedge clk_i or negedge rst_ni) begin : note_driver
    logic load;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      load = !in_valid;
      if (in_valid && in_ready) begin
        expected_results.push_back(allocate_note(driven_note));
        load = 1'b1;
      end
      if (load) begin
        if (pending_notes.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PERCENT)) begin
          driven_note = pending_notes.pop_front();
          in_valid   <= 1'b1;
          opcode_drv <= driven_note.opcode;
          key_drv    <= driven_note.key;
          busy_drv   <= driven_note.busy;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted result against the oldest
  // expectation and stalls the result channel at random.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    voice_result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected result transaction: action %0d voice %0d freq %0h",
                     action_mon, voice_mon, freq_mon);
        end else begin
          want = expected_results.pop_front();
          if (action_mon !== want.action || voice_mon !== want.voice ||
              freq_mon !== want.freq || sounding_mon !== want.sounding) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("mismatch: exp action %0d voice %0d freq %0h busy %0d,",
                       want.action, want.voice, want.freq, want.sounding,
                       " got action %0d voice %0d freq %0h busy %0d",
                       action_mon, voice_mon, freq_mon, sounding_mon);
          end
        end
      end
      out_ready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
    end
  end

  // Watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    for (i = 0; i < HW_VOICES; i++) begin
      tag_model[i]  = '0;
      live_model[i] = 1'b0;
      hold_model[i] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = {1'b0, {FREQ_W{1'b1}}};
    for (i = 2; i < POOL_SIZE; i++) key_pool[i] = {1'b0, FREQ_W'($urandom)};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed notes under the reset limit of eight voices
    push_note(OP_PLAY, 21'h000000, 8'h00); // start voice 0 at key zero
    push_note(OP_PLAY, 21'h0FFFFF, 8'h01); // top key, takes voice 1
    push_note(OP_PLAY, 21'h000000, 8'hFF); // match counts up
    push_note(OP_STOP, 21'h000000, 8'hAA); // count down, still held
    push_note(OP_STOP, 21'h000000, 8'h55); // last release frees voice 0
    push_note(OP_STOP, 21'h000000, 8'h00); // stop with no match
    push_note(OP_PLAY, 21'h1FFFFF, 8'h00); // minus one: ignored
    push_note(OP_STOP, 21'h100000, 8'h00); // most negative key: ignored
    push_note(OP_PLAY, 21'h100000, 8'h0F);
    push_note(OP_PLAY, 21'h00007B, 8'hFF); // no idle voice: dropped
    push_note(OP_PLAY, 21'h0FFFFF, 8'hFF); // match despite full busy mask
    push_note(OP_PLAY, 21'h0AAAAA, 8'hFE);
    push_note(OP_PLAY, 21'h055555, 8'h7F); // highest voice
    push_note(OP_STOP, 21'h0FFFFF, 8'h80);
    push_note(OP_STOP, 21'h0FFFFF, 8'h3C);
    push_note(OP_STOP, 21'h0AAAAA, 8'hC3);
    push_note(OP_STOP, 21'h055555, 8'h00);
    push_note(OP_PLAY, 21'h080000, 8'h0F);
    push_note(OP_PLAY, 21'h012345, 8'hFF);

    // Random phases across voice limits, extremes included; the state built
    // under one limit carries into the next
    run_phase(4'd8, 120);
    run_phase(4'd1, 80);
    run_phase(4'd3, 100);
    run_phase(4'd0, 30);  // nothing searched: plays drop, stops do nothing

    // Saturation run with no idling: hold one key past the count ceiling,
    // then release twice to show the count stuck at its maximum
    write_voice_limit(4'd8);
    no_gaps = 1'b1;
    repeat (SAT_PLAYS) push_note(OP_PLAY, key_pool[2], BUSY_W'($urandom));
    repeat (2) push_note(OP_STOP, key_pool[2], BUSY_W'($urandom));
    repeat (60) pending_notes.push_back(random_note());
    wait_drained();
    no_gaps = 1'b0;

    run_phase(4'd5, 100);
    run_phase(4'd2, 60);
    run_phase(4'd8, 100);

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/pva_pkg.sv
design/pva_voice_store.sv
design/polyphonic_voice_allocator_top.sv
verif/tb_polyphonic_voice_allocator_top.sv
